>>> src/mwwcs_pkg.sv
// Package for the multi-width window count statistic block.
// Holds widths, register indexes, the state type and the 1/sqrt coefficient table.
// No dependencies; every other file in src imports it.
package mwwcs_pkg;

    // Sizing of the window history and of the sequence.
    localparam int MAX_WIDTH = 32;
    localparam int MAX_LEN   = 4096;

    // Field widths of the registers and of the result beat.
    localparam int SEQ_W   = 13;
    localparam int LAG_W   = 12;
    localparam int WID_W   = 6;
    localparam int START_W = 12;
    localparam int FLAT_W  = 17;
    localparam int SCORE_W = 16;
    localparam int MAG_W   = SCORE_W - 1;
    localparam int POS_W   = 13;
    localparam int CMP_W   = POS_W + 1;
    localparam int IDX_W   = $clog2(MAX_WIDTH);
    localparam int ONES_W  = $clog2(MAX_WIDTH + 1);
    localparam int DIFF_W  = ONES_W + 2;

    // Position counter saturates at its all-ones value.
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int PADDR_W    = CFG_IDX_W + 2;
    localparam int PDATA_W    = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAG       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd3;

    // Score scaling: value = |d| * 2^SCALE_LOG2 / sqrt(r), coefficients carry
    // FRAC_W fraction bits so truncation error stays far below the distance
    // of any true value from a rounding boundary.
    localparam int SCALE_LOG2 = 11;
    localparam int FRAC_W     = 28;
    localparam int COEF_W     = SCALE_LOG2 + FRAC_W + 1;
    localparam int PROD_W     = COEF_W + WID_W;

    typedef logic [MAX_WIDTH-1:0][COEF_W-1:0] t_coef_tab;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_walk_state;

    // Entry r-1 is floor(2^(SCALE_LOG2+FRAC_W) / sqrt(r)), found as the
    // largest c with c*c*r <= 2^(2*(SCALE_LOG2+FRAC_W)), one bit at a time.
    function automatic t_coef_tab coef_table();
        t_coef_tab          tab;
        logic [COEF_W-1:0]  c;
        logic [COEF_W-1:0]  c_try;
        logic [127:0]       sq;
        for (int r = 1; r <= MAX_WIDTH; r++) begin
            c = '0;
            for (int b = COEF_W - 1; b >= 0; b--) begin
                c_try = c | (COEF_W'(1) << b);
                sq = 128'(c_try) * 128'(c_try) * 128'(r);
                if (sq <= (128'(1) << (2 * (SCALE_LOG2 + FRAC_W)))) begin
                    c = c_try;
                end
            end
            tab[r-1] = c;
        end
        return tab;
    endfunction

    localparam t_coef_tab COEF_TAB = coef_table();

endpackage

>>> src/mwwcs_if.sv
// Valid/ready channel interfaces for indicator beats and result beats.
// Depends on mwwcs_pkg for the field widths.
interface mwwcs_in_if;
    import mwwcs_pkg::*;

    logic valid;
    logic ready;
    logic indicator;
    logic first;

    modport source (output valid, output indicator, output first, input ready);
    modport sink   (input valid, input indicator, input first, output ready);
endinterface

interface mwwcs_out_if;
    import mwwcs_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic [WID_W-1:0]          width;
    logic [START_W-1:0]        start_res;
    logic [FLAT_W-1:0]         flat_index;
    logic                      last;

    modport source (output valid, output score, output width, output start_res,
                    output flat_index, output last, input ready);
    modport sink   (input valid, input score, input width, input start_res,
                    input flat_index, input last, output ready);
endinterface

>>> src/multiwidth_window_count_statistic.sv
// Multi-width window count statistic: top level with register port and datapath.
// Depends on mwwcs_pkg and the channel interfaces in mwwcs_if.sv.
// Idle takes each item; one that yields results starts a walk over widths 1..hi, where hi
// is the largest width emitted; the walk steps one width a cycle unless the output stalls.
// The result for a width moves from its walk step to the multiply stage, then the output register.
// Input ready is low while a walk is in progress; output stalls hold the walk in place.
// Reset (synchronous, active low) clears history, position, pipeline valids and loads
// the register defaults seq_len 4096, lag 1, min_width 1, max_width 32.
module multiwidth_window_count_statistic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mwwcs_in_if.sink                          i_in,
    mwwcs_out_if.source                       o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mwwcs_pkg::PADDR_W-1:0]     paddr,
    input  logic [mwwcs_pkg::PDATA_W-1:0]     pwdata,
    output logic [mwwcs_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);
    import mwwcs_pkg::*;

    // Configuration registers.
    logic [SEQ_W-1:0]     r_seq_len;
    logic [LAG_W-1:0]     r_lag;
    logic [WID_W-1:0]     r_min_w;
    logic [WID_W-1:0]     r_max_w;
    logic                 cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;

    // Sequence state.
    logic [MAX_WIDTH-1:0] r_hist;
    logic [POS_W-1:0]     r_pos;

    // Sequencer.
    t_walk_state r_state;
    t_walk_state n_state;
    logic        in_ready;
    logic        in_acc;
    logic        adv;
    logic        walk_step;
    logic        walk_last;

    // Per-item setup.
    logic [POS_W-1:0]     t_cur;
    logic [MAX_WIDTH-1:0] hist_new;
    logic [SEQ_W-1:0]     n_eff;
    logic                 in_range;
    logic [WID_W-1:0]     lo_eff;
    logic [WID_W-1:0]     hi_cfg;
    logic [CMP_W-1:0]     t_plus1;
    logic [WID_W-1:0]     hi_eff;
    logic                 start_walk;
    logic [FLAT_W-1:0]    base;

    // Walk registers.
    logic [WID_W-1:0]   r_r;
    logic [WID_W-1:0]   r_lo;
    logic [WID_W-1:0]   r_hi;
    logic [ONES_W-1:0]  r_ones;
    logic [FLAT_W-1:0]  r_off;
    logic [FLAT_W-1:0]  r_base;
    logic [START_W-1:0] r_t;

    // Walk datapath.
    logic [IDX_W-1:0]         bit_idx;
    logic [ONES_W-1:0]        ones_now;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;
    logic [WID_W-1:0]         a_mag;
    logic                     emit;
    logic [PROD_W-1:0]        prod;
    logic [START_W:0]         start_full;
    logic [START_W-1:0]       start_j;
    logic [FLAT_W-1:0]        flat;

    // Multiply stage.
    logic               r_p_valid;
    logic [PROD_W-1:0]  r_p_prod;
    logic               r_p_neg;
    logic [WID_W-1:0]   r_p_width;
    logic [START_W-1:0] r_p_start;
    logic [FLAT_W-1:0]  r_p_flat;
    logic               r_p_last;

    // Output stage.
    logic                      r_o_valid;
    logic signed [SCORE_W-1:0] r_o_score;
    logic [WID_W-1:0]          r_o_width;
    logic [START_W-1:0]        r_o_start;
    logic [FLAT_W-1:0]         r_o_flat;
    logic                      r_o_last;
    logic [PROD_W-1:0]         rounded;
    logic [MAG_W-1:0]          mag;

    // Register port: writes land on the access phase, reads are a plain mux.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len <= SEQ_W'(MAX_LEN);
            r_lag     <= LAG_W'(1);
            r_min_w   <= WID_W'(1);
            r_max_w   <= WID_W'(MAX_WIDTH);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SEQ_LEN:   r_seq_len <= pwdata[SEQ_W-1:0];
                REG_LAG:       r_lag     <= pwdata[LAG_W-1:0];
                REG_MIN_WIDTH: r_min_w   <= pwdata[WID_W-1:0];
                REG_MAX_WIDTH: r_max_w   <= pwdata[WID_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SEQ_LEN:   prdata = PDATA_W'(r_seq_len);
            REG_LAG:       prdata = PDATA_W'(r_lag);
            REG_MIN_WIDTH: prdata = PDATA_W'(r_min_w);
            REG_MAX_WIDTH: prdata = PDATA_W'(r_max_w);
            default:       prdata = '0;
        endcase
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign adv    = !r_o_valid || o_out.ready;
    assign in_acc = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Setup of a new item: shift in the bit, find the end position and width range.
    assign t_cur    = i_in.first ? '0 : r_pos;
    assign hist_new = i_in.first ? MAX_WIDTH'(i_in.indicator)
                                 : {r_hist[MAX_WIDTH-2:0], i_in.indicator};
    assign n_eff    = (r_seq_len > SEQ_W'(MAX_LEN)) ? SEQ_W'(MAX_LEN) : r_seq_len;
    assign in_range = (CMP_W'(t_cur) + CMP_W'(r_lag)) < CMP_W'(n_eff);
    assign lo_eff   = (r_min_w == '0) ? WID_W'(1) : r_min_w;
    assign hi_cfg   = (r_max_w > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : r_max_w;
    assign t_plus1  = CMP_W'(t_cur) + CMP_W'(1);
    assign hi_eff   = (CMP_W'(hi_cfg) > t_plus1) ? t_plus1[WID_W-1:0] : hi_cfg;
    assign start_walk = in_range && (lo_eff <= hi_eff);
    assign base     = FLAT_W'(n_eff) - FLAT_W'(r_lag) + FLAT_W'(1);

    // Sequencer: idle takes one item, walk steps widths 1..hi, one per advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        walk_step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_acc && start_walk) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                walk_step = adv;
                if (adv && walk_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // History and position follow every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_pos  <= '0;
        end else if (in_acc) begin
            r_hist <= hist_new;
            r_pos  <= (t_cur < POS_MAX) ? t_cur + POS_W'(1) : t_cur;
        end
    end

    // Walk datapath: running count of ones, signed difference and coefficient product.
    assign walk_last  = (r_r == r_hi);
    assign bit_idx    = IDX_W'(r_r - WID_W'(1));
    assign ones_now   = r_ones + ONES_W'(r_hist[bit_idx]);
    assign diff       = $signed(DIFF_W'(r_r)) - $signed(DIFF_W'({ones_now, 1'b0}));
    assign diff_abs   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign a_mag      = diff_abs[WID_W-1:0];
    assign emit       = walk_step && (r_r >= r_lo);
    assign prod       = PROD_W'(a_mag) * PROD_W'(COEF_TAB[bit_idx]);
    assign start_full = (START_W + 1)'(r_t) + (START_W + 1)'(1) - (START_W + 1)'(r_r);
    assign start_j    = start_full[START_W-1:0];
    assign flat       = r_off + FLAT_W'(start_j);

    always_ff @(posedge i_clk) begin
        if (in_acc && start_walk) begin
            r_r    <= WID_W'(1);
            r_ones <= '0;
            r_off  <= '0;
            r_lo   <= lo_eff;
            r_hi   <= hi_eff;
            r_t    <= t_cur[START_W-1:0];
            r_base <= base;
        end else if (walk_step) begin
            r_r    <= r_r + WID_W'(1);
            r_ones <= ones_now;
            if (r_r >= r_lo) begin
                r_off <= r_off + r_base - FLAT_W'(r_r);
            end
        end
    end

    // Multiply stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (adv) begin
            r_p_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_p_prod  <= prod;
            r_p_neg   <= diff[DIFF_W-1];
            r_p_width <= r_r;
            r_p_start <= start_j;
            r_p_flat  <= flat;
            r_p_last  <= walk_last;
        end
    end

    // Round half away from zero on the magnitude, then restore the sign.
    assign rounded = r_p_prod + (PROD_W'(1) << (FRAC_W - 1));
    assign mag     = rounded[FRAC_W +: MAG_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_p_valid) begin
            r_o_score <= r_p_neg ? -$signed(SCORE_W'(mag)) : $signed(SCORE_W'(mag));
            r_o_width <= r_p_width;
            r_o_start <= r_p_start;
            r_o_flat  <= r_p_flat;
            r_o_last  <= r_p_last;
        end
    end

    // Result channel.
    assign o_out.valid      = r_o_valid;
    assign o_out.score      = r_o_score;
    assign o_out.width      = r_o_width;
    assign o_out.start_res  = r_o_start;
    assign o_out.flat_index = r_o_flat;
    assign o_out.last       = r_o_last;

    // The walk never runs past its upper width and always starts at or below it.
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_r <= r_hi) && (r_lo <= r_hi) && (r_r != '0))
        else $error("width walk out of range");

    // Stepping the final width returns the sequencer to idle.
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && adv && walk_last) |=> (r_state == ST_IDLE))
        else $error("walk did not end on its last width");

    // Delivered widths lie within the history depth.
    a_out_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.width != '0) && (o_out.width <= WID_W'(MAX_WIDTH)))
        else $error("result width out of range");

    // A score never exceeds 2048*sqrt(MAX_WIDTH) in magnitude.
    a_score_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.score <= 16'sd11586) && (o_out.score >= -16'sd11586))
        else $error("score magnitude out of range");

    // A stalled result beat leaves the multiply stage untouched.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_out.ready && r_p_valid) |=> r_p_valid && $stable(r_p_prod))
        else $error("pipeline moved during an output stall");

endmodule

>>> tb/sv/tb_multiwidth_window_count_statistic.sv
// Self-checking testbench for multiwidth_window_count_statistic: sends indicator beats
// under many register settings, predicts every window score and checks each result beat.
// Depends on mwwcs_pkg and the channel interfaces in mwwcs_if.sv.
module tb_multiwidth_window_count_statistic;
    import mwwcs_pkg::*;

    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 50;

    typedef struct packed {
        logic indicator;
        logic first;
    } ind_beat_t;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [WID_W-1:0]          width;
        logic [START_W-1:0]        start_res;
        logic [FLAT_W-1:0]         flat_index;
        logic                      last;
    } window_result_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    mwwcs_in_if  in_ch ();
    mwwcs_out_if out_ch ();

    multiwidth_window_count_statistic dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow registers and window state of the scoring predictor.
    logic [SEQ_W-1:0]     cfg_seq_len = SEQ_W'(4096);
    logic [LAG_W-1:0]     cfg_lag     = LAG_W'(1);
    logic [WID_W-1:0]     cfg_min_w   = WID_W'(1);
    logic [WID_W-1:0]     cfg_max_w   = WID_W'(32);
    logic [MAX_WIDTH-1:0] hist_bits   = '0;
    logic [POS_W-1:0]     cur_pos     = '0;

    ind_beat_t      beat_queue[$];
    window_result_t expected_windows[$];
    window_result_t seen;
    window_result_t want;

    int unsigned beats_sent      = 0;
    int unsigned windows_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned settings_used   = 0;
    int          quiet_cycles    = 0;
    int          burst_left      = 1;
    int          gap_left        = 0;
    logic [15:0] ready_pat       = 16'hFFFF;
    int          pat_age         = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Shift in one indicator and queue the score of every window ending on it.
    function automatic void predict_windows(input logic ind, input logic first);
        window_result_t res;
        int unsigned    t, n, lo, hi, r, ones;
        int             d, b;
        longint         mag, limit, trial, q, m, base;
        if (first) begin
            hist_bits = '0;
            cur_pos   = '0;
        end
        hist_bits = {hist_bits[MAX_WIDTH-2:0], ind};
        t = cur_pos;
        if (cur_pos != POS_MAX) begin
            cur_pos = cur_pos + 1'b1;
        end
        n = (cfg_seq_len > MAX_LEN) ? MAX_LEN : cfg_seq_len;
        if (t + cfg_lag >= n) begin
            return;
        end
        lo = (cfg_min_w == 0) ? 1 : cfg_min_w;
        hi = (cfg_max_w > MAX_WIDTH) ? MAX_WIDTH : cfg_max_w;
        if (hi > t + 1) begin
            hi = t + 1;
        end
        base = 0;
        for (r = lo; r <= hi; r++) begin
            ones = $countones(64'(hist_bits) & ((64'd1 << r) - 64'd1));
            d    = int'(r) - 2 * int'(ones);
            // Largest m with r*(2m-1)^2 <= d^2 * 2^24, which is the rounded magnitude
            // of d*2048/sqrt(r) with ties going away from zero.
            mag   = (d < 0) ? -d : d;
            limit = (mag * mag) << 24;
            m     = 0;
            if (mag != 0) begin
                for (b = MAG_W - 1; b >= 0; b--) begin
                    trial = m | (longint'(1) << b);
                    q     = 2 * trial - 1;
                    if (longint'(r) * q * q <= limit) begin
                        m = trial;
                    end
                end
            end
            res.score      = SCORE_W'((d < 0) ? -m : m);
            res.width      = WID_W'(r);
            res.start_res  = START_W'(t - r + 1);
            res.flat_index = FLAT_W'(base + longint'(t - r + 1));
            res.last       = (r == hi);
            expected_windows.push_back(res);
            base += longint'(n) - longint'(r) - longint'(cfg_lag) + 1;
        end
    endfunction

    task automatic push_beat(input logic ind, input logic first);
        ind_beat_t beat;
        beat.indicator = ind;
        beat.first     = first;
        beat_queue.push_back(beat);
    endtask

    // Let every queued beat go out and every result come back, then let the block settle.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (beat_queue.size() != 0 || expected_windows.size() != 0 || in_ch.valid);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write one register over the configuration port, then read it back.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] field;
        case (idx)
            REG_SEQ_LEN: field = value & ((32'd1 << SEQ_W) - 1);
            REG_LAG:     field = value & ((32'd1 << LAG_W) - 1);
            default:     field = value & ((32'd1 << WID_W) - 1);
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= field;
        @(posedge i_clk);
        penable <= 1'b1;
        // The register takes the value at this edge; the read setup follows.
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SEQ_LEN:   cfg_seq_len = field[SEQ_W-1:0];
            REG_LAG:       cfg_lag     = field[LAG_W-1:0];
            REG_MIN_WIDTH: cfg_min_w   = field[WID_W-1:0];
            REG_MAX_WIDTH: cfg_max_w   = field[WID_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== field) begin
            mismatch_count++;
            $display("%0t: register %0d read back, expected %0d, actual %0d",
                     $time, idx, field, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input int unsigned seq_len, input int unsigned lag,
                                  input int unsigned min_w, input int unsigned max_w);
        write_register(REG_SEQ_LEN, seq_len);
        write_register(REG_LAG, lag);
        write_register(REG_MIN_WIDTH, min_w);
        write_register(REG_MAX_WIDTH, max_w);
        settings_used++;
    endtask

    // Indicator driver: presents queued beats in bursts separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_windows(beat_queue[0].indicator, beat_queue[0].first);
                void'(beat_queue.pop_front());
                beats_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (beat_queue.size() == 0 || gap_left > 0) begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end else begin
                    in_ch.valid     <= 1'b1;
                    in_ch.indicator <= beat_queue[0].indicator;
                    in_ch.first     <= beat_queue[0].first;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40)
                                                                 : $urandom_range(0, 2);
                    end
                end
            end
        end
    end

    // Result monitor: checks each accepted beat against the oldest prediction and
    // stalls on a rotating ready pattern that is redrawn now and then.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen = {out_ch.score, out_ch.width, out_ch.start_res, out_ch.flat_index,
                        out_ch.last};
                windows_checked++;
                if (expected_windows.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result beat with none expected: score %0d width %0d",
                             $time, $signed(seen.score), seen.width);
                    $display("%0t:   start %0d flat %0d last %0b",
                             $time, seen.start_res, seen.flat_index, seen.last);
                end else begin
                    want = expected_windows.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        $display("%0t: expected score %0d width %0d start %0d flat %0d last %0b",
                                 $time, $signed(want.score), want.width, want.start_res,
                                 want.flat_index, want.last);
                        $display("%0t:   actual score %0d width %0d start %0d flat %0d last %0b",
                                 $time, $signed(seen.score), seen.width, seen.start_res,
                                 seen.flat_index, seen.last);
                    end
                end
            end
            if (pat_age <= 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pat = 16'hFFFF;
                    1:       ready_pat = 16'($urandom);
                    2:       ready_pat = 16'($urandom | $urandom);
                    default: ready_pat = 16'($urandom & $urandom);
                endcase
                ready_pat[0] = 1'b1;
                pat_age      = $urandom_range(20, 200);
            end
            pat_age--;
            out_ch.ready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: directed cases, then random phases.
    initial begin : stimulus
        int unsigned n_eff, span, len, kind, density, left, seq_v, lag_v, min_v, max_v;
        int          ph, k;
        logic        bit_v, first_v, paused;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        paused          = 1'b0;
        i_rst_n         = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: a short sequence, then a restart in the middle of it.
        push_beat(1'b1, 1'b1);
        push_beat(1'b0, 1'b0);
        push_beat(1'b1, 1'b0);
        push_beat(1'b1, 1'b0);
        push_beat(1'b0, 1'b0);
        push_beat(1'b0, 1'b1);
        push_beat(1'b0, 1'b0);
        wait_idle();

        // Zero minimum width, maximum width and length above their limits.
        apply_settings(8191, 0, 0, 63);
        push_beat(1'b1, 1'b1);
        push_beat(1'b0, 1'b0);
        push_beat(1'b1, 1'b0);
        push_beat(1'b0, 1'b0);
        wait_idle();

        // Lag not below the sequence length gives nothing.
        apply_settings(1, 4095, 1, 32);
        push_beat(1'b1, 1'b1);
        push_beat(1'b0, 1'b0);
        wait_idle();

        // Empty width range gives nothing either.
        apply_settings(4096, 0, 5, 2);
        push_beat(1'b1, 1'b1);
        push_beat(1'b1, 1'b0);
        push_beat(1'b0, 1'b0);
        push_beat(1'b1, 1'b0);
        push_beat(1'b1, 1'b0);
        push_beat(1'b0, 1'b0);
        wait_idle();

        // Short sequence: bits past the last valid end position are only stored.
        apply_settings(5, 2, 1, 4);
        push_beat(1'b1, 1'b1);
        push_beat(1'b0, 1'b0);
        push_beat(1'b1, 1'b0);
        push_beat(1'b1, 1'b0);
        push_beat(1'b0, 1'b0);
        push_beat(1'b1, 1'b0);
        wait_idle();

        // Random phases: mostly whole sequences with random content, some noise.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                apply_settings(4096, 0, 1, 32);
            end else if (ph == 1) begin
                apply_settings(40, 0, 1, 32);
            end else begin
                case ($urandom_range(0, 3))
                    0, 1:    seq_v = $urandom_range(1, 40);
                    2:       seq_v = $urandom_range(1, 8191);
                    default: seq_v = MAX_LEN;
                endcase
                lag_v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 6);
                min_v = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 12);
                case ($urandom_range(0, 5))
                    0:       max_v = 63;
                    1:       max_v = $urandom_range(0, 63);
                    default: max_v = $urandom_range(min_v, 32);
                endcase
                apply_settings(seq_v, lag_v, min_v, max_v);
            end
            left = PHASE_BEATS;
            while (left > 0) begin
                n_eff = (cfg_seq_len > MAX_LEN) ? MAX_LEN : cfg_seq_len;
                span  = (n_eff > cfg_lag) ? n_eff - cfg_lag : 1;
                kind  = $urandom_range(0, 9);
                if (kind == 0) begin
                    len = $urandom_range(1, 5);
                end else begin
                    len = span + $urandom_range(0, 3);
                end
                if (len > 40) begin
                    len = 40;
                end
                if (len > left) begin
                    len = left;
                end
                density = $urandom_range(0, 4);
                for (k = 0; k < len; k++) begin
                    case (density)
                        0:       bit_v = $urandom_range(0, 1);
                        1:       bit_v = 1'b1;
                        2:       bit_v = 1'b0;
                        3:       bit_v = ($urandom_range(0, 7) != 0);
                        default: bit_v = ($urandom_range(0, 7) == 0);
                    endcase
                    // Noise carries random restarts; a continuation carries none.
                    if (kind == 0) begin
                        first_v = $urandom_range(0, 1);
                    end else if (kind == 1) begin
                        first_v = 1'b0;
                    end else begin
                        first_v = (k == 0);
                    end
                    push_beat(bit_v, first_v);
                end
                left -= len;
                // Hold the sender once until every pending result is back.
                if (ph == 3 && !paused && left < PHASE_BEATS / 2) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d indicator beats under %0d register settings, including",
                 beats_sent, settings_used + 1);
        $display("clamped and empty ranges and short sequences; %0d result beats, %0d errors.",
                 windows_checked, mismatch_count);
        if (mismatch_count == 0 && expected_windows.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
